// ===== sv/scdp_pkg.sv =====
// Package for the segmentation clustering block: widths, cost infinity,
// configuration register indexes, sequencer state type and control struct.
// No dependencies.
package scdp_pkg;

    // Default sizes for the top-level parameters.
    localparam int DEF_MAX_SEGMENTS = 16;
    localparam int DEF_MAX_CLASSES  = 4;
    localparam int DEF_MAX_LENGTH   = 65536;

    // Fixed field widths.
    localparam int SAMPLE_W   = 16;
    localparam int POS_W      = 16;
    localparam int ROW_W      = 4;
    localparam int COST_W     = 50;
    localparam int SQ_W       = 32;
    localparam int NUM_MEANS  = 4;
    localparam int MEAN_IDX_W = 2;
    localparam int CC_W       = 3;
    localparam int SC_W       = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // All ones stands for an infinite cost.
    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT = 3'd5;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROW,
        ST_RD,
        ST_UPD,
        ST_CMP,
        ST_EMIT
    } t_state;

    // Strobes from the sequencer to the datapath.
    typedef struct packed {
        logic accept;
        logic clear;
        logic sq_en;
        logic row_start;
        logic rd;
        logic upd;
        logic cmp;
        logic emit;
    } t_ctl;

endpackage

// ===== sv/scdp_sqr.sv =====
// Squared-difference unit: one shared subtract and multiply, computing
// (sample - mean)^2 for one class per cycle into a small register file.
// Depends on scdp_pkg.
module scdp_sqr import scdp_pkg::*; #(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    localparam int LW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
    input  logic                       i_clk,
    input  t_ctl                       i_ctl,
    input  logic        [LW-1:0]       i_l,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_mean [NUM_MEANS],
    output logic        [SQ_W-1:0]     o_sq
);

    logic signed [SAMPLE_W-1:0] r_x;
    logic        [SQ_W-1:0]     r_sq [MAX_CLASSES];
    logic signed [SAMPLE_W:0]   w_diff;
    logic        [SAMPLE_W-1:0] w_abs;
    logic        [SQ_W-1:0]     w_prod;

    // Difference, magnitude and square for the class under the counter.
    always_comb begin
        w_diff = {r_x[SAMPLE_W-1], r_x}
                 - {i_mean[MEAN_IDX_W'(i_l)][SAMPLE_W-1], i_mean[MEAN_IDX_W'(i_l)]};
        w_abs  = w_diff[SAMPLE_W] ? SAMPLE_W'(-w_diff) : w_diff[SAMPLE_W-1:0];
        w_prod = SQ_W'(w_abs) * SQ_W'(w_abs);
    end

    // Sample capture on request and square register file.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_x <= i_sample;
        end
        if (i_ctl.sq_en) begin
            r_sq[i_l] <= w_prod;
        end
    end

    assign o_sq = r_sq[i_l];

endmodule

// ===== sv/scdp_cost.sv =====
// Cost datapath: class cost and segment start memories, previous-row best
// memory, the shared saturating adder and the running minimum over classes.
// Depends on scdp_pkg.
module scdp_cost import scdp_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
    localparam int KW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int LW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
    localparam int PW = $clog2(MAX_LENGTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctl              i_ctl,
    input  logic [KW-1:0]     i_k,
    input  logic [LW-1:0]     i_l,
    input  logic [PW-1:0]     i_pos,
    input  logic [SQ_W-1:0]   i_sq,
    output logic [COST_W-1:0] o_best,
    output logic [PW-1:0]     o_where
);

    localparam int DEPTH = MAX_SEGMENTS * MAX_CLASSES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Memories; entries not yet written read as their reset value.
    logic [COST_W-1:0] mem_cost  [DEPTH];
    logic [PW-1:0]     mem_start [DEPTH];
    logic [COST_W-1:0] mem_pb    [MAX_SEGMENTS];
    logic [DEPTH-1:0]        r_cv;
    logic [MAX_SEGMENTS-1:0] r_pbv;

    logic [COST_W-1:0] r_cost_rd;
    logic [PW-1:0]     r_start_rd;
    logic              r_cv_rd;
    logic [COST_W-1:0] r_pb_rd;
    logic              r_pbv_rd;
    logic [COST_W-1:0] r_up;
    logic [COST_W-1:0] r_new;
    logic [PW-1:0]     r_new_start;
    logic [COST_W-1:0] r_best;
    logic [PW-1:0]     r_where;

    logic [AW-1:0]     w_addr;
    logic              w_row0;
    logic [COST_W-1:0] w_cost;
    logic [PW-1:0]     w_start;
    logic              w_open;
    logic [COST_W-1:0] w_op;
    logic [COST_W:0]   w_sum;
    logic [COST_W-1:0] w_new;
    logic [PW-1:0]     w_new_start;

    // Address of the current row and class.
    assign w_addr = AW'(int'(i_k) * MAX_CLASSES + int'(i_l));
    assign w_row0 = (i_k == '0);

    // Cost update: open a new segment when the class cost exceeds the
    // previous row's best, otherwise extend; then add the square, saturating.
    always_comb begin
        w_cost      = r_cv_rd ? r_cost_rd : (w_row0 ? '0 : COST_INF);
        w_start     = r_cv_rd ? r_start_rd : '0;
        w_open      = !w_row0 && (w_cost > r_up);
        w_op        = w_open ? r_up : w_cost;
        w_sum       = {1'b0, w_op} + (COST_W + 1)'(i_sq);
        w_new       = (w_sum >= {1'b0, COST_INF}) ? COST_INF : w_sum[COST_W-1:0];
        w_new_start = w_open ? i_pos : w_start;
    end

    // Class memories: read in one step, write back in the next.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_cost_rd  <= mem_cost[w_addr];
            r_start_rd <= mem_start[w_addr];
        end
        if (i_ctl.upd) begin
            mem_cost[w_addr]  <= w_new;
            mem_start[w_addr] <= w_new_start;
        end
    end

    // Previous-row best memory: read at row start, written when the row emits.
    always_ff @(posedge i_clk) begin
        if (i_ctl.row_start) begin
            r_pb_rd <= mem_pb[i_k];
        end
        if (i_ctl.emit) begin
            mem_pb[i_k] <= r_best;
        end
    end

    // Valid bits; a new sequence clears them all at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_cv  <= '0;
            r_pbv <= '0;
        end else begin
            if (i_ctl.upd) begin
                r_cv[w_addr] <= 1'b1;
            end
            if (i_ctl.emit) begin
                r_pbv[i_k] <= 1'b1;
            end
        end
    end

    // Registered valid flags, updated alongside the memory reads.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_cv_rd <= r_cv[w_addr];
        end
        if (i_ctl.row_start) begin
            r_pbv_rd <= r_pbv[i_k];
        end
    end

    // New cost, running minimum and the best row value carried to the next row.
    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_new       <= w_new;
            r_new_start <= w_new_start;
        end
        if (i_ctl.row_start) begin
            r_best  <= COST_INF;
            r_where <= '0;
        end else if (i_ctl.cmp && (i_l == '0 || r_new < r_best)) begin
            r_best  <= r_new;
            r_where <= w_row0 ? '0 : r_new_start;
        end
        if (i_ctl.emit) begin
            r_up <= r_pbv_rd ? r_pb_rd : COST_INF;
        end
    end

    assign o_best  = r_best;
    assign o_where = r_where;

endmodule

// ===== sv/scdp_seq.sv =====
// Sequencer: walks the classes for the squares, then each row and each
// class through read, update and compare; owns the position counter.
// Depends on scdp_pkg.
module scdp_seq import scdp_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int MAX_LENGTH   = DEF_MAX_LENGTH,
    localparam int KW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int LW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
    localparam int PW = $clog2(MAX_LENGTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_sos,
    input  logic [CC_W-1:0] i_class_count,
    input  logic [SC_W-1:0] i_segment_count,
    input  logic            i_out_free,
    output logic            o_in_stall,
    output t_ctl            o_ctl,
    output logic [KW-1:0]   o_k,
    output logic [LW-1:0]   o_l,
    output logic [PW-1:0]   o_pos,
    output logic            o_reach,
    output logic            o_row_last
);

    localparam int NCW = $clog2(MAX_CLASSES + 1);
    localparam int NRW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [PW-1:0] POS_MAX = PW'(MAX_LENGTH - 1);

    t_state          r_state, n_state;
    logic [KW-1:0]   r_k, n_k;
    logic [LW-1:0]   r_l, n_l;
    logic [PW-1:0]   r_pos, n_pos;
    logic [NCW-1:0]  w_ncls;
    logic [NRW-1:0]  w_nrows;
    logic            w_l_last;
    t_ctl            w_ctl;

    // Register values outside the supported range are clamped.
    always_comb begin
        if (i_class_count == '0) begin
            w_ncls = NCW'(1);
        end else if (int'(i_class_count) > MAX_CLASSES) begin
            w_ncls = NCW'(MAX_CLASSES);
        end else begin
            w_ncls = NCW'(i_class_count);
        end
        if (i_segment_count == '0) begin
            w_nrows = NRW'(1);
        end else if (int'(i_segment_count) > MAX_SEGMENTS) begin
            w_nrows = NRW'(MAX_SEGMENTS);
        end else begin
            w_nrows = NRW'(i_segment_count);
        end
    end

    assign w_l_last   = (NCW'(r_l) == w_ncls - 1'b1);
    assign o_row_last = (NRW'(r_k) == w_nrows - 1'b1);
    assign o_reach    = (32'(r_pos) >= 32'(r_k));

    // State register and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_l     <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_l     <= n_l;
            r_pos   <= n_pos;
        end
    end

    // Next state and strobes.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_l     = r_l;
        n_pos   = r_pos;
        w_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_ctl.accept = 1'b1;
                    w_ctl.clear  = i_sos;
                    if (i_sos) begin
                        n_pos = '0;
                    end
                    n_l     = '0;
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                w_ctl.sq_en = 1'b1;
                if (w_l_last) begin
                    n_l     = '0;
                    n_k     = '0;
                    n_state = ST_ROW;
                end else begin
                    n_l = r_l + 1'b1;
                end
            end
            ST_ROW: begin
                w_ctl.row_start = 1'b1;
                n_l     = '0;
                n_state = o_reach ? ST_RD : ST_EMIT;
            end
            ST_RD: begin
                w_ctl.rd = 1'b1;
                n_state  = ST_UPD;
            end
            ST_UPD: begin
                w_ctl.upd = 1'b1;
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                w_ctl.cmp = 1'b1;
                if (w_l_last) begin
                    n_state = ST_EMIT;
                end else begin
                    n_l     = r_l + 1'b1;
                    n_state = ST_RD;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    w_ctl.emit = 1'b1;
                    if (o_row_last) begin
                        if (r_pos != POS_MAX) begin
                            n_pos = r_pos + 1'b1;
                        end
                        n_state = ST_IDLE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_ROW;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctl      = w_ctl;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_k        = r_k;
    assign o_l        = r_l;
    assign o_pos      = r_pos;

`ifndef ASSERT_OFF
    // An accepted request starts with the first class's square.
    a_accept_to_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_SQ && r_l == '0))
        else $error("accepted request did not start the square phase");

    // The last row's result returns the sequencer to idle.
    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.emit && o_row_last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after the last row");
`endif

endmodule

// ===== sv/segment_cluster_dp_top.sv =====
// Segmentation clustering by class means, streaming dynamic programming.
//
// Input channel: i_in_valid / o_in_stall carry one sample request with
// i_sample (Q5.10) and i_start_of_sequence, which restarts the costs and the
// position counter before that sample is used.
// Output channel: o_out_valid / i_out_stall carry one result per active row,
// rows in increasing order, o_last_in_run marking the final row.
// Configuration: i_cfg_we writes register i_cfg_index (means 0..3, class
// count, segment count) from i_cfg_data; write only while the block is idle.
// Steps: a sample holds the block from its acceptance in idle through the
// squares, one class per cycle, then for each row a row start, a read,
// update and compare step per class when the row is reachable, and an emit;
// an unreachable row has only the row start and the emit. The shared adder
// sees one class of one row each read, update and compare step, and the
// squares use one multiplier. The first result is loaded at row 0's emit.
// A stalled receiver holds the output register; the sequencer waits at the
// end of the row until the register frees, and no result is lost.
// Reset restores the register defaults and starts an empty sequence.
module segment_cluster_dp_top import scdp_pkg::*; #(
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
    parameter int MAX_CLASSES  = DEF_MAX_CLASSES,
    parameter int MAX_LENGTH   = DEF_MAX_LENGTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_start_of_sequence,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic        [ROW_W-1:0]    o_segment_row,
    output logic        [POS_W-1:0]    o_sample_position,
    output logic        [COST_W-1:0]   o_best_cost,
    output logic        [POS_W-1:0]    o_change_position,
    output logic                       o_reachable,
    output logic                       o_last_in_run,
    input  logic                       i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic        [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int KW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int LW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int PW = $clog2(MAX_LENGTH);

    logic signed [SAMPLE_W-1:0] r_mean [NUM_MEANS];
    logic        [CC_W-1:0]     r_class_count;
    logic        [SC_W-1:0]     r_segment_count;

    t_ctl              w_ctl;
    logic [KW-1:0]     w_k;
    logic [LW-1:0]     w_l;
    logic [PW-1:0]     w_pos;
    logic              w_reach;
    logic              w_row_last;
    logic              w_out_free;
    logic [SQ_W-1:0]   w_sq;
    logic [COST_W-1:0] w_best;
    logic [PW-1:0]     w_where;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_o_row;
    logic [POS_W-1:0]  r_o_pos;
    logic [COST_W-1:0] r_o_best;
    logic [POS_W-1:0]  r_o_change;
    logic              r_o_reach;
    logic              r_o_last;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MEANS; m++) begin
                r_mean[m] <= '0;
            end
            r_class_count   <= CC_W'(4);
            r_segment_count <= SC_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MEAN_0:        r_mean[0] <= i_cfg_data;
                CFG_MEAN_1:        r_mean[1] <= i_cfg_data;
                CFG_MEAN_2:        r_mean[2] <= i_cfg_data;
                CFG_MEAN_3:        r_mean[3] <= i_cfg_data;
                CFG_CLASS_COUNT:   r_class_count <= i_cfg_data[CC_W-1:0];
                CFG_SEGMENT_COUNT: r_segment_count <= i_cfg_data[SC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    scdp_seq #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_CLASSES  (MAX_CLASSES),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_sos           (i_start_of_sequence),
        .i_class_count   (r_class_count),
        .i_segment_count (r_segment_count),
        .i_out_free      (w_out_free),
        .o_in_stall      (o_in_stall),
        .o_ctl           (w_ctl),
        .o_k             (w_k),
        .o_l             (w_l),
        .o_pos           (w_pos),
        .o_reach         (w_reach),
        .o_row_last      (w_row_last)
    );

    scdp_sqr #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_sqr (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_l      (w_l),
        .i_sample (i_sample),
        .i_mean   (r_mean),
        .o_sq     (w_sq)
    );

    scdp_cost #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .MAX_CLASSES  (MAX_CLASSES),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_k     (w_k),
        .i_l     (w_l),
        .i_pos   (w_pos),
        .i_sq    (w_sq),
        .o_best  (w_best),
        .o_where (w_where)
    );

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload, loaded once per row.
    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_o_row    <= ROW_W'(w_k);
            r_o_pos    <= POS_W'(w_pos);
            r_o_best   <= w_best;
            r_o_change <= POS_W'(w_where);
            r_o_reach  <= w_reach;
            r_o_last   <= w_row_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_segment_row     = r_o_row;
    assign o_sample_position = r_o_pos;
    assign o_best_cost       = r_o_best;
    assign o_change_position = r_o_change;
    assign o_reachable       = r_o_reach;
    assign o_last_in_run     = r_o_last;

`ifndef ASSERT_OFF
    // A result is only loaded when the output register is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending result");

    // An unreachable row reports an infinite cost and no change position.
    a_unreachable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_reachable) |->
        (o_best_cost == COST_INF && o_change_position == '0))
        else $error("unreachable row with finite cost or change position");
`endif

endmodule
